[hdl/skvt_pkg.sv]
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared types, constants and helpers for the sorted key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

    // table geometry
    localparam int ENTRIES     = 32;
    localparam int KEY_BYTES   = 8;
    localparam int VALUE_BYTES = 8;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int KEY_W = 64;
    localparam int VAL_W = 64;
    localparam int POS_W = 5;
    localparam int TOT_W = 6;

    // request opcodes
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_DEL  = 2'd1;
    localparam logic [1:0] OP_FIND = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_DELETED   = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_FOUND     = 3'd5;

    // request payload
    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] name_key;
        logic [VAL_W-1:0] phone_value;
    } t_req;

    // result payload
    typedef struct packed {
        logic [2:0]       status;
        logic [POS_W-1:0] position;
        logic [VAL_W-1:0] value_out;
        logic [TOT_W-1:0] entry_total;
    } t_res;

    // comparator outcome, a against b
    typedef struct packed {
        logic gt;
        logic eq;
    } t_cmp;

    // keep leading bytes up to the first zero byte or the byte limit
    function automatic logic [63:0] as_string(input logic [63:0] x, input int nbytes);
        logic        alive;
        logic [63:0] r;
        begin
            alive = 1'b1;
            r     = '0;
            for (int i = 0; i < 8; i++) begin
                if (i >= nbytes || x[63-8*i -: 8] == 8'd0) begin
                    alive = 1'b0;
                end
                if (alive) begin
                    r[63-8*i -: 8] = x[63-8*i -: 8];
                end
            end
            return r;
        end
    endfunction

    // low bits of a count-sized value as a result position
    function automatic logic [POS_W-1:0] to_pos(input logic [CNT_W-1:0] x);
        logic [CNT_W+POS_W-1:0] t;
        begin
            t = {{POS_W{1'b0}}, x};
            return t[POS_W-1:0];
        end
    endfunction

    // low bits of a count-sized value as a result total
    function automatic logic [TOT_W-1:0] to_tot(input logic [CNT_W-1:0] x);
        logic [CNT_W+TOT_W-1:0] t;
        begin
            t = {{TOT_W{1'b0}}, x};
            return t[TOT_W-1:0];
        end
    endfunction

endpackage

[hdl/skvt_ram.sv]
// ----------------------------------------------------------------------------
// skvt_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module skvt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/skvt_cmp.sv]
// ----------------------------------------------------------------------------
// skvt_cmp
// Shared key comparator: unsigned greater-than and equality of two keys.
// ----------------------------------------------------------------------------
module skvt_cmp (
    input  logic [skvt_pkg::KEY_W-1:0] i_a,
    input  logic [skvt_pkg::KEY_W-1:0] i_b,
    output skvt_pkg::t_cmp             o_res
);
    import skvt_pkg::*;

    // one wide compare serves both search steps and the final match check
    always_comb begin
        o_res.gt = (i_a > i_b);
        o_res.eq = (i_a == i_b);
    end

endmodule

[hdl/sorted_key_value_table_top.sv]
// ----------------------------------------------------------------------------
// sorted_key_value_table_top
// Sorted key/value table with add/update, delete and find requests.
// ----------------------------------------------------------------------------
// A request is taken only while o_in_stall is low and holds the block until
// its result is built. A binary search over the n valid entries reads the
// memory and then compares at each halving step. The final slot is then read
// and a resolve step follows. An insert or delete then moves one entry per
// cycle through the single read and write port of the key and value memories.
// The longest case is a delete at the head of a full table of 32 entries. A
// rejected add on a full table or an unused opcode goes straight from the
// accept step to the finish step. A finished result waits while the output
// register still holds a stalled one. The result sits in that output
// register, so the next request is accepted while it waits.
// ----------------------------------------------------------------------------
module sorted_key_value_table_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  skvt_pkg::t_req i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output skvt_pkg::t_res o_out_res
);
    import skvt_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SRCH  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_RSLV  = 3'd3;
    localparam logic [2:0] S_SHIFT = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_pend, n_pend;
    logic             r_out_valid, n_out_valid;
    t_res             r_out, n_out;

    logic [1:0]       r_op, n_op;
    logic [KEY_W-1:0] r_key, n_key;
    logic [VAL_W-1:0] r_val, n_val;
    logic [CNT_W-1:0] r_lo, n_lo;
    logic [CNT_W-1:0] r_hi, n_hi;
    logic [IDX_W-1:0] r_mid, n_mid;
    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [IDX_W-1:0] r_wdst, n_wdst;
    logic [CNT_W-1:0] r_left, n_left;
    logic [2:0]       r_status, n_status;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [VAL_W-1:0] r_vout, n_vout;

    logic             key_we, val_we;
    logic [IDX_W-1:0] waddr, raddr;
    logic [KEY_W-1:0] key_wdata, rd_key;
    logic [VAL_W-1:0] val_wdata, rd_val;
    t_cmp             cmp;
    logic [CNT_W:0]   mid_sum;
    logic [CNT_W-1:0] mid;
    logic             found;
    logic             is_ins;
    logic [1:0]       req_op;

    // key and value memories share addresses
    skvt_ram #(.WIDTH(KEY_W), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (waddr),
        .i_wdata (key_wdata),
        .i_raddr (raddr),
        .o_rdata (rd_key)
    );

    skvt_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (waddr),
        .i_wdata (val_wdata),
        .i_raddr (raddr),
        .o_rdata (rd_val)
    );

    // request key against the entry just read
    skvt_cmp u_cmp (
        .i_a   (r_key),
        .i_b   (rd_key),
        .o_res (cmp)
    );

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid     = mid_sum[CNT_W:1];
    assign found   = (r_lo < r_count) && cmp.eq;
    assign is_ins  = (r_op == OP_ADD);
    assign req_op  = i_in_req.opcode;

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pend      = r_pend;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_op        = r_op;
        n_key       = r_key;
        n_val       = r_val;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_ptr       = r_ptr;
        n_wdst      = r_wdst;
        n_left      = r_left;
        n_status    = r_status;
        n_pos       = r_pos;
        n_vout      = r_vout;
        key_we      = 1'b0;
        val_we      = 1'b0;
        waddr       = r_wdst;
        raddr       = r_ptr;
        key_wdata   = rd_key;
        val_wdata   = rd_val;

        // result taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = req_op;
                    n_key    = as_string(i_in_req.name_key, KEY_BYTES);
                    n_val    = as_string(i_in_req.phone_value, VALUE_BYTES);
                    n_lo     = '0;
                    n_hi     = r_count;
                    n_pos    = '0;
                    n_vout   = '0;
                    n_status = ST_NOT_FOUND;
                    if (req_op == OP_ADD && r_count >= CNT_W'(ENTRIES)) begin
                        n_status = ST_FULL;
                        n_state  = S_FIN;
                    end else if (req_op == OP_ADD || req_op == OP_DEL ||
                                 req_op == OP_FIND) begin
                        n_state = S_SRCH;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_SRCH: begin
                if (r_lo == r_hi) begin
                    raddr   = r_lo[IDX_W-1:0];
                    n_state = S_RSLV;
                end else begin
                    raddr   = mid[IDX_W-1:0];
                    n_mid   = mid[IDX_W-1:0];
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                // first slot whose key is not below the request key
                if (cmp.gt) begin
                    n_lo = CNT_W'(r_mid) + 1'b1;
                end else begin
                    n_hi = CNT_W'(r_mid);
                end
                n_state = S_SRCH;
            end
            S_RSLV: begin
                n_pend = 1'b0;
                case (r_op)
                    OP_ADD: begin
                        n_pos = r_lo;
                        if (found) begin
                            val_we    = 1'b1;
                            waddr     = r_lo[IDX_W-1:0];
                            val_wdata = r_val;
                            n_status  = ST_UPDATED;
                            n_state   = S_FIN;
                        end else begin
                            n_status = ST_INSERTED;
                            n_ptr    = IDX_W'(r_count - 1'b1);
                            n_left   = r_count - r_lo;
                            n_state  = S_SHIFT;
                        end
                    end
                    OP_DEL: begin
                        if (found) begin
                            n_status = ST_DELETED;
                            n_pos    = r_lo;
                            n_ptr    = IDX_W'(r_lo + 1'b1);
                            n_left   = r_count - r_lo - 1'b1;
                            n_state  = S_SHIFT;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    default: begin
                        if (found) begin
                            n_status = ST_FOUND;
                            n_pos    = r_lo;
                            n_vout   = rd_val;
                        end
                        n_state = S_FIN;
                    end
                endcase
            end
            S_SHIFT: begin
                // write back the entry read last cycle
                if (r_pend) begin
                    key_we = 1'b1;
                    val_we = 1'b1;
                end
                if (r_left != '0) begin
                    raddr  = r_ptr;
                    n_wdst = is_ins ? (r_ptr + 1'b1) : (r_ptr - 1'b1);
                    n_ptr  = is_ins ? (r_ptr - 1'b1) : (r_ptr + 1'b1);
                    n_left = r_left - 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        if (is_ins) begin
                            key_we    = 1'b1;
                            val_we    = 1'b1;
                            waddr     = r_lo[IDX_W-1:0];
                            key_wdata = r_key;
                            val_wdata = r_val;
                            n_count   = r_count + 1'b1;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                        n_state = S_FIN;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.status      = r_status;
                    n_out.position    = to_pos(r_pos);
                    n_out.value_out   = r_vout;
                    n_out.entry_total = to_tot(r_count);
                    n_out_valid       = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_op     <= n_op;
        r_key    <= n_key;
        r_val    <= n_val;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_ptr    <= n_ptr;
        r_wdst   <= n_wdst;
        r_left   <= n_left;
        r_status <= n_status;
        r_pos    <= n_pos;
        r_vout   <= n_vout;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

    // entry count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(ENTRIES))
        else $error("entry count beyond table size");

    // count only moves at the end of a shift pass
    a_count_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_count != $past(r_count)) |-> $past(r_state) == S_SHIFT)
        else $error("entry count changed outside shift");

    // search window never inverts
    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH || r_state == S_CMP) |-> r_lo <= r_hi)
        else $error("search window inverted");

    // a new result only comes from the finish step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_out_valid)) |-> $past(r_state) == S_FIN)
        else $error("result raised outside finish step");

endmodule
